// ===== hdl/contactor_feedback_supervisor_core_macros.svh =====
// assertion macros for the contactor feedback supervisor
// no dependencies; included by the top level only
`ifndef CONTACTOR_FEEDBACK_SUPERVISOR_CORE_MACROS_SVH
`define CONTACTOR_FEEDBACK_SUPERVISOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define CFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfs assertion failed");
// next-cycle implication, disabled during reset
`define CFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfs assertion failed");
`else
`define CFS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/cfs_pkg.sv =====
// shared codes, widths and helpers of the contactor feedback supervisor
// no dependencies; used by the channel interfaces and the top level
package cfs_pkg;

    // field widths
    localparam int CMD_W     = 2;
    localparam int STATE_W   = 4;
    localparam int LED_W     = 2;
    localparam int STAMP_W   = 32;
    localparam int DELAY_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // commands
    localparam logic [CMD_W-1:0] CMD_POLL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INIT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ON   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_OFF  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_DELAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_DELAY = 2'd2;

    // unit states
    localparam logic [STATE_W-1:0] PH_UNKNOWN            = 4'd0;
    localparam logic [STATE_W-1:0] PH_OFF                = 4'd1;
    localparam logic [STATE_W-1:0] PH_STARTING           = 4'd2;
    localparam logic [STATE_W-1:0] PH_ON                 = 4'd3;
    localparam logic [STATE_W-1:0] PH_STOPPING           = 4'd4;
    localparam logic [STATE_W-1:0] PH_ERR_FLOOR          = 4'd4;
    localparam logic [STATE_W-1:0] PH_ERR_OFF_DRIVEN     = 4'd5;
    localparam logic [STATE_W-1:0] PH_ERR_OFF_FB_CLOSED  = 4'd6;
    localparam logic [STATE_W-1:0] PH_ERR_START_UNDRIVEN = 4'd7;
    localparam logic [STATE_W-1:0] PH_ERR_START_FB_OPEN  = 4'd8;
    localparam logic [STATE_W-1:0] PH_ERR_STOP_DRIVEN    = 4'd9;
    localparam logic [STATE_W-1:0] PH_ERR_STOP_FB_CLOSED = 4'd10;
    localparam logic [STATE_W-1:0] PH_ERR_STOP_UNDRIVEN  = 4'd11;
    localparam logic [STATE_W-1:0] PH_ERR_STOP_FB_OPEN   = 4'd12;
    localparam logic [STATE_W-1:0] PH_ERR_ON_UNDRIVEN    = 4'd13;
    localparam logic [STATE_W-1:0] PH_ERR_ON_FB_OPEN     = 4'd14;

    // led patterns
    localparam logic [LED_W-1:0] LED_OFF    = 2'd0;
    localparam logic [LED_W-1:0] LED_STEADY = 2'd1;
    localparam logic [LED_W-1:0] LED_BLINK  = 2'd2;
    localparam logic [LED_W-1:0] LED_FAST   = 2'd3;

    // led pattern that belongs to a unit state
    function automatic logic [LED_W-1:0] led_for(input logic [STATE_W-1:0] ph);
        logic [LED_W-1:0] led;
        if (ph == PH_ON)
            led = LED_STEADY;
        else if (ph == PH_STARTING || ph == PH_STOPPING)
            led = LED_BLINK;
        else if (ph > PH_ERR_FLOOR)
            led = LED_FAST;
        else
            led = LED_OFF;
        return led;
    endfunction

endpackage

// ===== hdl/cfs_if.sv =====
// valid/ready channel interfaces for command items and status results
// depends on cfs_pkg
interface cfs_item_if;
    import cfs_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic               feedback;
    logic [STAMP_W-1:0] now_time;

    modport source (output valid, output command, output feedback, output now_time,
                    input ready);
    modport sink   (input valid, input command, input feedback, input now_time,
                    output ready);
endinterface

interface cfs_result_if;
    import cfs_pkg::*;

    logic               valid;
    logic               ready;
    logic [STATE_W-1:0] unit_state;
    logic               drive_out;
    logic [LED_W-1:0]   led_mode;
    logic               state_changed;

    modport source (output valid, output unit_state, output drive_out, output led_mode,
                    output state_changed, input ready);
    modport sink   (input valid, input unit_state, input drive_out, input led_mode,
                    input state_changed, output ready);
endinterface

// ===== hdl/contactor_feedback_supervisor_core.sv =====
// contactor feedback supervisor: input register, state update, result register
// depends on cfs_pkg, cfs_if.sv and contactor_feedback_supervisor_core_macros.svh
//
// Usage:
//   item_ch carries one command (poll, init, turn on, turn off), the feedback
//   contact level and a free running millisecond timestamp per transaction.
//   result_ch returns exactly one status transaction per item: unit state,
//   drive level, led pattern and a state-changed flag.
//   cfg_we/cfg_index/cfg_wdata write unit mode, on delay and off delay; write
//   them only while no item is in flight.
// Timing:
//   an item is held in the input register, the state update and the delay
//   check (a subtract over TIME_WIDTH bits and a compare over the wider of
//   TIME_WIDTH and DELAY_W) run between it and the result register, which then
//   holds its status. One item per cycle is accepted while result_ch does not stall.
// Reset and stalls:
//   reset empties both registers, sets the unit state to unknown, drive and
//   led off, timer disarmed, and the registers to contactor mode, 1000 ms and
//   1000 ms. While result_ch stalls the result register holds, the input
//   register fills once more and then item_ch.ready drops.
`include "contactor_feedback_supervisor_core_macros.svh"

module contactor_feedback_supervisor_core #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    cfs_item_if.sink                       item_ch,
    cfs_result_if.source                   result_ch,
    input  logic                           cfg_we,
    input  logic [cfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cfs_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
    import cfs_pkg::*;

    localparam int CMP_W = (TIME_WIDTH > DELAY_W) ? TIME_WIDTH : DELAY_W;

    // configuration registers
    logic               unit_mode_reg;
    logic [DELAY_W-1:0] on_delay_reg;
    logic [DELAY_W-1:0] off_delay_reg;

    // supervisor state
    logic [STATE_W-1:0]    phase_reg,  phase_next;
    logic                  drive_reg,  drive_next;
    logic [TIME_WIDTH-1:0] start_reg,  start_next;
    logic                  armed_reg,  armed_next;
    logic                  last_fb_reg, last_fb_next;
    logic [LED_W-1:0]      led_reg,    led_next;

    // input register
    logic               in_valid_reg;
    logic [CMD_W-1:0]   cmd_reg;
    logic               fb_reg;
    logic [STAMP_W-1:0] stamp_reg;

    // result register
    logic               out_valid_reg;
    logic [STATE_W-1:0] out_state_reg;
    logic               out_drive_reg;
    logic [LED_W-1:0]   out_led_reg;
    logic               out_changed_reg;

    logic                  advance;
    logic                  out_free;
    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] diff_t;
    logic [DELAY_W-1:0]    delay_sel;
    logic                  delay_done;
    logic [STATE_W-1:0]    before_state;
    logic [STATE_W-1:0]    after_state;

    // handshake: result register frees when taken, input register moves on into it
    assign out_free      = !out_valid_reg || result_ch.ready;
    assign advance       = in_valid_reg && out_free;
    assign item_ch.ready = !in_valid_reg || out_free;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_mode_reg <= 1'b0;
            on_delay_reg  <= DELAY_W'(1000);
            off_delay_reg <= DELAY_W'(1000);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_UNIT_MODE: unit_mode_reg <= cfg_wdata[0];
                CFG_ON_DELAY:  on_delay_reg  <= cfg_wdata[DELAY_W-1:0];
                CFG_OFF_DELAY: off_delay_reg <= cfg_wdata[DELAY_W-1:0];
                default:       ;
            endcase
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item_ch.ready)
            in_valid_reg <= item_ch.valid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (item_ch.valid && item_ch.ready)
        begin
            cmd_reg   <= item_ch.command;
            fb_reg    <= item_ch.feedback;
            stamp_reg <= item_ch.now_time;
        end
    end

    // wrapping elapsed time against the delay of the current phase
    assign now_t      = TIME_WIDTH'(stamp_reg);
    assign diff_t     = now_t - start_reg;
    assign delay_sel  = (phase_reg == PH_STARTING) ? on_delay_reg : off_delay_reg;
    assign delay_done = CMP_W'(diff_t) > CMP_W'(delay_sel);

    assign before_state = unit_mode_reg ? (last_fb_reg ? PH_ON : PH_OFF) : phase_reg;

    // state update for the item in the input register
    always_comb
    begin
        logic [STATE_W-1:0] old_ph;
        logic               do_poll;

        old_ph       = phase_reg;
        phase_next   = phase_reg;
        drive_next   = drive_reg;
        start_next   = start_reg;
        armed_next   = armed_reg;
        last_fb_next = last_fb_reg;
        led_next     = led_reg;

        // init resets to off before polling
        if (cmd_reg == CMD_INIT)
        begin
            last_fb_next = fb_reg;
            if (unit_mode_reg)
                drive_next = 1'b0;
            phase_next = PH_OFF;
            led_next   = LED_OFF;
        end

        do_poll = (cmd_reg == CMD_POLL) || (cmd_reg == CMD_INIT) || !unit_mode_reg;

        if (do_poll && unit_mode_reg)
        begin
            // automat: report the feedback only
            if (last_fb_next != fb_reg)
                led_next = fb_reg ? LED_STEADY : LED_OFF;
            last_fb_next = fb_reg;
        end
        else if (do_poll)
        begin
            old_ph = phase_next;
            unique case (phase_next)
                PH_OFF:
                begin
                    if (drive_next)
                        phase_next = PH_ERR_OFF_DRIVEN;
                    else if (fb_reg)
                        phase_next = PH_ERR_OFF_FB_CLOSED;
                end
                PH_STARTING:
                begin
                    if (!armed_next)
                    begin
                        drive_next = 1'b1;
                        start_next = now_t;
                        armed_next = 1'b1;
                    end
                    else if (delay_done)
                        phase_next = PH_ON;
                    if (!drive_next)
                        phase_next = PH_ERR_START_UNDRIVEN;
                    else if (!fb_reg)
                        phase_next = PH_ERR_START_FB_OPEN;
                end
                PH_STOPPING:
                begin
                    if (!armed_next)
                    begin
                        start_next = now_t;
                        armed_next = 1'b1;
                    end
                    else if (delay_done)
                    begin
                        drive_next = 1'b0;
                        phase_next = PH_OFF;
                    end
                    if (phase_next == PH_OFF)
                    begin
                        if (drive_next)
                            phase_next = PH_ERR_STOP_DRIVEN;
                        else if (fb_reg)
                            phase_next = PH_ERR_STOP_FB_CLOSED;
                    end
                    else if (!drive_next)
                        phase_next = PH_ERR_STOP_UNDRIVEN;
                    else if (!fb_reg)
                        phase_next = PH_ERR_STOP_FB_OPEN;
                end
                PH_ON:
                begin
                    if (!drive_next)
                        phase_next = PH_ERR_ON_UNDRIVEN;
                    else if (!fb_reg)
                        phase_next = PH_ERR_ON_FB_OPEN;
                end
                // unknown and error states latch
                default: ;
            endcase
            last_fb_next = fb_reg;
            if (old_ph != phase_next)
                led_next = led_for(phase_next);
        end

        // turn commands act after the poll, contactor mode only
        if (!unit_mode_reg && cmd_reg == CMD_ON && phase_next == PH_OFF)
        begin
            armed_next = 1'b0;
            phase_next = PH_STARTING;
            led_next   = LED_BLINK;
        end
        else if (!unit_mode_reg && cmd_reg == CMD_OFF &&
                 (phase_next == PH_ON || phase_next == PH_STARTING))
        begin
            armed_next = 1'b0;
            phase_next = PH_STOPPING;
            led_next   = LED_BLINK;
        end
    end

    assign after_state = unit_mode_reg ? (last_fb_next ? PH_ON : PH_OFF) : phase_next;

    // supervisor state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_UNKNOWN;
            drive_reg   <= 1'b0;
            start_reg   <= '0;
            armed_reg   <= 1'b0;
            last_fb_reg <= 1'b0;
            led_reg     <= LED_OFF;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            drive_reg   <= drive_next;
            start_reg   <= start_next;
            armed_reg   <= armed_next;
            last_fb_reg <= last_fb_next;
            led_reg     <= led_next;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_state_reg   <= after_state;
            out_drive_reg   <= drive_next;
            out_led_reg     <= led_next;
            out_changed_reg <= (after_state != before_state);
        end
    end

    assign result_ch.valid         = out_valid_reg;
    assign result_ch.unit_state    = out_state_reg;
    assign result_ch.drive_out     = out_drive_reg;
    assign result_ch.led_mode      = out_led_reg;
    assign result_ch.state_changed = out_changed_reg;

    // a transferred item always shows up as a pending result
    `CFS_ASSERT_NEXT(a_advance_fills, clk, rst_n, advance, out_valid_reg)
    // the on state is only held with the drive energized
    `CFS_ASSERT_NOW(a_on_driven, clk, rst_n, phase_reg == PH_ON, drive_reg)
    // the unused state code never arises
    `CFS_ASSERT_NOW(a_state_range, clk, rst_n, 1'b1, phase_reg <= PH_ERR_ON_FB_OPEN)

endmodule
